// ----- design/actm_pkg.sv -----
package actm_pkg;

	localparam int TW = 32;
	localparam int SW = TW - 1;
	localparam int N = 2 * TW - 1;
	localparam int QD = 4;
	localparam int QAW = $clog2(QD);

	typedef enum logic [1:0] {
		MODE_ONCE = 2'd0,
		MODE_STAY = 2'd1,
		MODE_LOOP = 2'd2,
		MODE_PING = 2'd3
	} mode_t;

	localparam logic [1:0] REG_START = 2'd0;
	localparam logic [1:0] REG_SPAN = 2'd1;
	localparam logic [1:0] REG_DUR = 2'd2;
	localparam logic [1:0] REG_MODE = 2'd3;

	typedef struct packed {
		logic [TW-1:0] start;
		logic [SW-1:0] span;
		logic [SW-1:0] dur;
		mode_t mode;
	} cfg_t;

	typedef struct packed {
		logic neg;
		logic [SW-1:0] span;
		logic [TW-1:0] start;
		mode_t mode;
		logic [7:0] prio;
		logic [N-1:0] scaled;
	} side_t;

	typedef struct packed {
		logic [N-1:0] num;
		logic [SW-1:0] dvs;
		side_t side;
	} entry_t;

endpackage

// ----- design/actm_front.sv -----
module actm_front (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input actm_pkg::cfg_t cfg,
	input logic [actm_pkg::TW-1:0] event_time,
	input logic [7:0] priority_req,
	output logic [1:0] inflight,
	output logic push,
	output actm_pkg::entry_t entry
);
	import actm_pkg::*;

	logic v_s1;
	logic neg_s1;
	logic [TW-1:0] mag_s1;
	cfg_t cfg_s1;
	logic [7:0] prio_s1;
	logic v_s2;
	entry_t entry_s2;

	logic [TW:0] diff;
	logic [TW:0] diff_abs;
	logic [N-1:0] prod;
	logic [SW-1:0] dur_eff;

	assign diff = {event_time[TW-1], event_time} - {cfg.start[TW-1], cfg.start};
	assign diff_abs = diff[TW] ? (~diff + 1'b1) : diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			neg_s1 <= diff[TW];
			mag_s1 <= diff_abs[TW-1:0];
			cfg_s1 <= cfg;
			prio_s1 <= priority_req;
		end
	end

	assign prod = mag_s1 * cfg_s1.span;
	assign dur_eff = (cfg_s1.dur != '0) ? cfg_s1.dur : cfg_s1.span;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	// With no duration and no span the ratio is taken as one: divide the elapsed time by one.
	always_ff @(posedge clk) begin
		if (v_s1) begin
			if (dur_eff == '0) begin
				entry_s2.num <= {{(N-TW){1'b0}}, mag_s1};
				entry_s2.dvs <= SW'(1);
			end else begin
				entry_s2.num <= prod;
				entry_s2.dvs <= dur_eff;
			end
			entry_s2.side.neg <= neg_s1;
			entry_s2.side.span <= cfg_s1.span;
			entry_s2.side.start <= cfg_s1.start;
			entry_s2.side.mode <= cfg_s1.mode;
			entry_s2.side.prio <= prio_s1;
			entry_s2.side.scaled <= '0;
		end
	end

	assign inflight = {v_s2, v_s1};
	assign push = v_s2;
	assign entry = entry_s2;

endmodule

// ----- design/actm_queue.sv -----
module actm_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input actm_pkg::entry_t wr_entry,
	output logic pop,
	output actm_pkg::entry_t rd_entry,
	output logic [actm_pkg::QAW:0] count
);
	import actm_pkg::*;

	entry_t mem_q [QD];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0] cnt_q;

	// The back end drains one entry in every cycle in which the queue holds one.
	assign pop = (cnt_q != '0);
	assign rd_entry = mem_q[rd_ptr_q];
	assign count = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (QAW+1)'(push) - (QAW+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q < (QAW+1)'(QD)) || pop)
		else $error("transfer into a full queue");

	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QAW+1)'(1))
		else $error("queue holds more than one entry");

endmodule

// ----- design/actm_div.sv -----
module actm_div (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [actm_pkg::N-1:0] num,
	input logic [actm_pkg::SW-1:0] dvs,
	input actm_pkg::side_t in_side,
	output logic out_valid,
	output logic [actm_pkg::N-1:0] quot,
	output logic [actm_pkg::SW-1:0] rem,
	output actm_pkg::side_t out_side
);
	import actm_pkg::*;

	// One quotient bit per stage; the dividend shifts out at the top while
	// quotient bits shift in at the bottom.
	logic v_s [1:N];
	logic [SW-1:0] rem_s [1:N];
	logic [N-1:0] n_s [1:N];
	logic [SW-1:0] d_s [1:N];
	side_t sd_s [1:N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic src_v;
		logic [SW-1:0] src_rem;
		logic [N-1:0] src_n;
		logic [SW-1:0] src_d;
		side_t src_sd;
		logic [SW:0] trial;
		logic [SW:0] sub;
		logic ge;

		if (k == 0) begin : g_first
			assign src_v = in_valid;
			assign src_rem = '0;
			assign src_n = num;
			assign src_d = dvs;
			assign src_sd = in_side;
		end else begin : g_next
			assign src_v = v_s[k];
			assign src_rem = rem_s[k];
			assign src_n = n_s[k];
			assign src_d = d_s[k];
			assign src_sd = sd_s[k];
		end

		assign trial = {src_rem, src_n[N-1]};
		assign sub = trial - {1'b0, src_d};
		assign ge = (trial >= {1'b0, src_d});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (src_v) begin
				rem_s[k+1] <= ge ? sub[SW-1:0] : trial[SW-1:0];
				n_s[k+1] <= {src_n[N-2:0], ge};
				d_s[k+1] <= src_d;
				sd_s[k+1] <= src_sd;
			end
		end
	end

	assign out_valid = v_s[N];
	assign quot = n_s[N];
	assign rem = rem_s[N];
	assign out_side = sd_s[N];

endmodule

// ----- design/actm_back.sv -----
module actm_back (
	input logic clk,
	input logic arst_n,
	input logic pop,
	input actm_pkg::entry_t entry,
	output logic done,
	output logic [actm_pkg::TW-1:0] local_time,
	output logic still_playing,
	output logic [7:0] priority_out
);
	import actm_pkg::*;

	localparam logic [N-1:0] POS_MAX = N'({1'b0, {(TW-1){1'b1}}});
	localparam logic [N-1:0] NEG_MAG = N'({1'b1, {(TW-1){1'b0}}});

	logic v1;
	logic [N-1:0] q1;
	logic [SW-1:0] r1;
	side_t sd1;
	side_t sd1_fwd;
	logic v2;
	logic [N-1:0] q2;
	logic [SW-1:0] r2;
	side_t sd2;

	logic past;
	logic [TW-1:0] lt;
	logic playing;
	logic [SW:0] fold_up;
	logic [SW:0] fold_dn;

	logic done_q;
	logic [TW-1:0] local_time_q;
	logic still_playing_q;
	logic [7:0] priority_out_q;

	function automatic logic [TW-1:0] sat(input logic neg, input logic [N-1:0] mag);
		logic [TW-1:0] res;
		if (!neg) begin
			res = (mag > POS_MAX) ? POS_MAX[TW-1:0] : mag[TW-1:0];
		end else begin
			res = (mag > NEG_MAG) ? NEG_MAG[TW-1:0] : (~mag[TW-1:0] + 1'b1);
		end
		return res;
	endfunction

	actm_div u_scale (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(pop),
		.num(entry.num),
		.dvs(entry.dvs),
		.in_side(entry.side),
		.out_valid(v1),
		.quot(q1),
		.rem(r1),
		.out_side(sd1)
	);

	always_comb begin
		sd1_fwd = sd1;
		sd1_fwd.scaled = q1;
	end

	// A zero span is replaced by one here; loop and ping-pong ignore the result then.
	actm_div u_wrap (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v1),
		.num(q1),
		.dvs((sd1.span != '0) ? sd1.span : SW'(1)),
		.in_side(sd1_fwd),
		.out_valid(v2),
		.quot(q2),
		.rem(r2),
		.out_side(sd2)
	);

	assign past = !sd2.neg && (sd2.scaled > {{(N-SW){1'b0}}, sd2.span});
	assign fold_up = {1'b0, sd2.span} + {1'b0, r2};
	assign fold_dn = {1'b0, sd2.span} - {1'b0, r2};

	always_comb begin
		playing = 1'b1;
		lt = sat(sd2.neg, sd2.scaled);
		unique case (sd2.mode)
			MODE_ONCE: begin
				if (past) begin
					lt = {1'b0, sd2.span};
					playing = 1'b0;
				end
			end
			MODE_STAY: begin
				if (past) begin
					lt = {1'b0, sd2.span};
				end
			end
			MODE_LOOP: begin
				if (sd2.span == '0) begin
					lt = sd2.start;
				end else if (past) begin
					lt = {1'b0, r2};
				end
			end
			MODE_PING: begin
				if (sd2.span == '0) begin
					lt = sd2.start;
				end else if (q2[0]) begin
					lt = sd2.neg ? sat(1'b0, {{(N-SW-1){1'b0}}, fold_up})
						: sat(1'b0, {{(N-SW-1){1'b0}}, fold_dn});
				end else begin
					lt = sat(sd2.neg, {{(N-SW){1'b0}}, r2});
				end
			end
			default: begin
				lt = sat(sd2.neg, sd2.scaled);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v2;
		end
	end

	always_ff @(posedge clk) begin
		if (v2) begin
			local_time_q <= lt;
			still_playing_q <= playing;
			priority_out_q <= sd2.prio;
		end
	end

	assign done = done_q;
	assign local_time = local_time_q;
	assign still_playing = still_playing_q;
	assign priority_out = priority_out_q;

	a_finished_once: assert property (@(posedge clk) disable iff (!arst_n)
		v2 && !playing |-> sd2.mode == MODE_ONCE && lt == {1'b0, sd2.span})
		else $error("finished flag outside a once clip past its end");

	a_chain: assert property (@(posedge clk) disable iff (!arst_n)
		v2 |-> sd2.scaled == $past(q1, N))
		else $error("scaled time lost between the dividers");

endmodule

// ----- design/animation_clip_time_mapper.sv -----
// Clip time mapper: each transfer on start/event_time/priority_req yields exactly one
// result, presented for a single cycle with done high; the receiver cannot stall it.
// A new query may be issued in every cycle. From the accepting edge to done a query passes
// two front stages (elapsed time, then the span multiply), one queue slot, and two
// bit-per-stage pipelined dividers, the first scaling by the playback duration and the second
// wrapping by the clip span.
// busy stays low in normal use. Configuration is written through cfg_we/cfg_index/cfg_data
// and is sampled with each query, so it should only change while no query is in flight.
module animation_clip_time_mapper (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [actm_pkg::TW-1:0] cfg_data,
	input logic start,
	output logic busy,
	input logic [actm_pkg::TW-1:0] event_time,
	input logic [7:0] priority_req,
	output logic done,
	output logic [actm_pkg::TW-1:0] local_time,
	output logic still_playing,
	output logic [7:0] priority_out
);
	import actm_pkg::*;

	localparam int LAT = 2 * N + 4;

	cfg_t cfg_q;
	logic accept;
	logic [1:0] inflight;
	logic push;
	entry_t push_entry;
	logic pop;
	entry_t pop_entry;
	logic [QAW:0] count;
	logic [QAW+1:0] load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start <= '0;
			cfg_q.span <= '0;
			cfg_q.dur <= '0;
			cfg_q.mode <= MODE_LOOP;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START: cfg_q.start <= cfg_data;
				REG_SPAN: cfg_q.span <= cfg_data[SW-1:0];
				REG_DUR: cfg_q.dur <= cfg_data[SW-1:0];
				REG_MODE: cfg_q.mode <= mode_t'(cfg_data[1:0]);
				default: cfg_q.mode <= cfg_q.mode;
			endcase
		end
	end

	// Hold off new queries while the front stages could overrun the queue.
	assign load = (QAW+2)'(count) + (QAW+2)'(inflight[0]) + (QAW+2)'(inflight[1]);
	assign busy = (load >= (QAW+2)'(QD));
	assign accept = start && !busy;

	actm_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.cfg(cfg_q),
		.event_time(event_time),
		.priority_req(priority_req),
		.inflight(inflight),
		.push(push),
		.entry(push_entry)
	);

	actm_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_entry(push_entry),
		.pop(pop),
		.rd_entry(pop_entry),
		.count(count)
	);

	actm_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop(pop),
		.entry(pop_entry),
		.done(done),
		.local_time(local_time),
		.still_playing(still_playing),
		.priority_out(priority_out)
	);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("front end stalled although the back end drains every cycle");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(accept, LAT))
		else $error("result transfer does not match an accepted query");

endmodule

// ----- bench/animation_clip_time_mapper_tb.sv -----
`timescale 1ns / 100ps

module animation_clip_time_mapper_tb;
	import actm_pkg::*;

	localparam int LATENCY = 2 * (2 * TW - 1) + 3;

	typedef struct {
		logic [TW-1:0] lt;
		logic playing;
		logic [7:0] prio;
	} clip_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [TW-1:0] cfg_data;
	logic start;
	logic busy;
	logic [TW-1:0] event_time;
	logic [7:0] priority_req;
	logic done;
	logic [TW-1:0] local_time;
	logic still_playing;
	logic [7:0] priority_out;

	// Shadow copy of the registers, updated as each write lands.
	logic [TW-1:0] sh_start;
	logic [SW-1:0] sh_span;
	logic [SW-1:0] sh_dur;
	mode_t sh_mode;

	clip_result_t pending_results[$];
	int n_errors;
	int n_sent;
	int n_checked;

	animation_clip_time_mapper u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.event_time(event_time),
		.priority_req(priority_req),
		.done(done),
		.local_time(local_time),
		.still_playing(still_playing),
		.priority_out(priority_out)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [TW-1:0] clamp_time(bit neg, bit [63:0] v);
		if (!neg) begin
			if (v > 64'h7FFF_FFFF) begin
				return 32'h7FFF_FFFF;
			end
			return v[TW-1:0];
		end
		if (v > 64'h8000_0000) begin
			return 32'h8000_0000;
		end
		return TW'(-v);
	endfunction

	function automatic clip_result_t map_time(logic [TW-1:0] ev, logic [7:0] prio);
		clip_result_t r;
		longint elapsed;
		bit neg;
		bit [63:0] mag, span, dur, scaled, periods, rem;
		bit past;
		elapsed = longint'($signed(ev)) - longint'($signed(sh_start));
		neg = elapsed < 0;
		mag = neg ? 64'(-elapsed) : 64'(elapsed);
		span = 64'(sh_span);
		dur = (sh_dur != 0) ? 64'(sh_dur) : span;
		// The product stays below 2**63, so 64 bits hold it exactly.
		scaled = (dur == 0) ? mag : (mag * span) / dur;
		past = !neg && scaled > span;
		r.playing = 1'b1;
		r.prio = prio;
		case (sh_mode)
			MODE_ONCE: begin
				if (past) begin
					r.lt = TW'(span);
					r.playing = 1'b0;
				end else begin
					r.lt = clamp_time(neg, scaled);
				end
			end
			MODE_STAY: begin
				r.lt = past ? TW'(span) : clamp_time(neg, scaled);
			end
			MODE_LOOP: begin
				if (span == 0) begin
					r.lt = sh_start;
				end else if (past) begin
					r.lt = TW'(scaled % span);
				end else begin
					r.lt = clamp_time(neg, scaled);
				end
			end
			default: begin
				if (span == 0) begin
					r.lt = sh_start;
				end else begin
					periods = scaled / span;
					rem = scaled % span;
					if (periods[0]) begin
						r.lt = neg ? clamp_time(1'b0, span + rem) : clamp_time(1'b0, span - rem);
					end else begin
						r.lt = clamp_time(neg, rem);
					end
				end
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [TW-1:0] got, logic [TW-1:0] want);
		$display("mismatch on %s: got %h, expected %h (result %0d)", what, got, want, n_checked);
		n_errors++;
	endtask

	always @(posedge clk) begin
		clip_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", local_time, '0);
			end else begin
				want = pending_results.pop_front();
				if (local_time !== want.lt) begin
					report_mismatch("local_time", local_time, want.lt);
				end
				if (still_playing !== want.playing) begin
					report_mismatch("still_playing", TW'(still_playing), TW'(want.playing));
				end
				if (priority_out !== want.prio) begin
					report_mismatch("priority_out", TW'(priority_out), TW'(want.prio));
				end
			end
			n_checked++;
		end
	end

	// Holds start high across back-to-back transfers; the caller lowers it for gaps.
	task automatic send_query(logic [TW-1:0] ev, logic [7:0] prio);
		start <= 1'b1;
		event_time <= ev;
		priority_req <= prio;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		pending_results.insert(pending_results.size(), map_time(ev, prio));
		n_sent++;
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	// Writes all four registers on consecutive edges; only called while drained.
	task automatic write_config(logic [TW-1:0] st, logic [SW-1:0] sp, logic [SW-1:0] du,
			mode_t md);
		cfg_we <= 1'b1;
		cfg_index <= REG_START;
		cfg_data <= st;
		@(posedge clk);
		sh_start = st;
		cfg_index <= REG_SPAN;
		cfg_data <= {1'b0, sp};
		@(posedge clk);
		sh_span = sp;
		cfg_index <= REG_DUR;
		cfg_data <= {1'b0, du};
		@(posedge clk);
		sh_dur = du;
		cfg_index <= REG_MODE;
		cfg_data <= TW'(md);
		@(posedge clk);
		sh_mode = md;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [TW-1:0] pick_time();
		int unsigned sel;
		logic [TW-1:0] off;
		sel = $urandom_range(99);
		if (sel < 60) begin
			// Around the clip, a few periods either side of its start.
			off = TW'($urandom_range(0, 8 * (sh_dur + sh_span) + 8));
			if ($urandom_range(1)) begin
				off = -off;
			end
			return sh_start + off;
		end else if (sel < 70) begin
			return sh_start + TW'($urandom_range(0, 3)) - 2;
		end
		return $urandom;
	endfunction

	task automatic test_reset_defaults();
		send_query(32'h0000_0000, 8'h00);
		send_query(32'h7FFF_FFFF, 8'hFF);
		send_query(32'h8000_0000, 8'hA5);
		wait_drained();
	endtask

	task automatic test_directed_modes();
		mode_t md;
		for (int m = 0; m < 4; m++) begin
			md = mode_t'(m);
			write_config(32'd100, 31'd10, 31'd20, md);
			send_query(32'd100, 8'h01);
			send_query(32'd119, 8'h02);
			send_query(32'd120, 8'h03);
			send_query(32'd155, 8'h04);
			send_query(32'd60, 8'h05);
			wait_drained();
			// Zero duration, then zero span with zero duration.
			write_config(32'hFFFF_FFF0, 31'd7, 31'd0, md);
			send_query(32'd20, 8'h10);
			send_query(32'hFFFF_FFE0, 8'h11);
			wait_drained();
			write_config(32'h8000_0000, 31'd0, 31'd0, md);
			send_query(32'h7FFF_FFFF, 8'h20);
			send_query(32'h8000_0000, 8'h21);
			wait_drained();
			// Large negative elapsed time scaled up saturates at the low end in the once, stay and loop modes.
			write_config(32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd1, md);
			send_query(32'h8000_0000, 8'h30);
			send_query(32'h7FFF_FFFE, 8'h31);
			wait_drained();
		end
	endtask

	task automatic test_random_phase(int idle_pct, int n_items);
		for (int i = 0; i < n_items; i++) begin
			if (i % 100 == 0) begin
				wait_drained();
				case ($urandom_range(3))
					0: write_config($urandom, 31'($urandom_range(0, 3)), 31'($urandom_range(0, 3)),
							mode_t'($urandom_range(3)));
					1: write_config($urandom, 31'h7FFF_FFFF, 31'($urandom),
							mode_t'($urandom_range(3)));
					default: write_config($urandom, 31'($urandom_range(1, 1000)),
							31'($urandom_range(0, 3000)), mode_t'($urandom_range(3)));
				endcase
			end
			send_query(pick_time(), 8'($urandom));
			// Each cycle is left idle with the given chance, so that share of cycles is idle.
			while (int'($urandom_range(99)) < idle_pct) begin
				start <= 1'b0;
				@(posedge clk);
			end
		end
		wait_drained();
	endtask

	initial begin
		n_errors = 0;
		n_sent = 0;
		n_checked = 0;
		sh_start = '0;
		sh_span = '0;
		sh_dur = '0;
		sh_mode = MODE_LOOP;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_START;
		cfg_data = '0;
		start = 1'b0;
		event_time = '0;
		priority_req = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_directed_modes();
		test_random_phase(0, 400);
		test_random_phase(70, 400);
		test_random_phase(0, 400);
		test_random_phase(22, 400);

		$display("Covered all four play modes with zero span, zero duration and extreme times;");
		$display("%0d queries sent, %0d results checked, sender gaps of 0/22/70 percent.",
			n_sent, n_checked);
		if (n_errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
